>>> design/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants of the stage latency statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package stl_pkg;

	localparam int unsigned ID_W     = 10;
	localparam int unsigned STAGE_W  = 8;
	localparam int unsigned TIME_W   = 64;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned S_DATA_W = 88;
	localparam int unsigned M_DATA_W = 288;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic [TIME_W-1:0]  sumsq;
		logic [TIME_W-1:0]  max;
		logic [TIME_W-1:0]  min;
		logic [COUNT_W-1:0] count;
	} stat_t;

	typedef struct packed {
		logic              seen;
		logic [TIME_W-1:0] last;
	} id_entry_t;

	localparam stat_t STAT_EMPTY = '{sumsq: '0, max: '0, min: '1, count: '0};
	localparam stat_t STAT_ZERO  = '{sumsq: '0, max: '0, min: '0, count: '0};

endpackage

`default_nettype wire

>>> design/stl_id_mem.sv
// ----------------------------------------------------------------------------
// stl_id_mem
// Per-id table: start flag and time of the last point, one read and one
// write port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_id_mem #(
	parameter int unsigned ID_ENTRIES = 1024,
	parameter int unsigned IDX_W      = 10
) (
	input  wire logic                 clk,
	input  wire logic                 rd_en,
	input  wire logic [IDX_W-1:0]     rd_addr,
	output stl_pkg::id_entry_t        rd_data,
	input  wire logic                 wr_en,
	input  wire logic [IDX_W-1:0]     wr_addr,
	input  wire stl_pkg::id_entry_t   wr_data
);

	stl_pkg::id_entry_t mem [ID_ENTRIES];
	stl_pkg::id_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> design/stl_stage_mem.sv
// ----------------------------------------------------------------------------
// stl_stage_mem
// Per-stage statistics table with a valid bit for each entry; an entry not
// yet written reads as the empty statistics.
// ----------------------------------------------------------------------------
`default_nettype none

module stl_stage_mem #(
	parameter int unsigned STAGE_ENTRIES = 256,
	parameter int unsigned SIDX_W        = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rd_en,
	input  wire logic [SIDX_W-1:0] rd_addr,
	output stl_pkg::stat_t         rd_stat,
	input  wire logic              wr_en,
	input  wire logic [SIDX_W-1:0] wr_addr,
	input  wire stl_pkg::stat_t    wr_stat
);

	stl_pkg::stat_t             mem [STAGE_ENTRIES];
	stl_pkg::stat_t             rd_data_q;
	logic [STAGE_ENTRIES-1:0]   valid_q;
	logic                       rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_stat;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_stat = rd_valid_q ? rd_data_q : stl_pkg::STAT_EMPTY;

endmodule

`default_nettype wire

>>> design/stage_latency_statistics_core.sv
// ----------------------------------------------------------------------------
// stage_latency_statistics_core
// Per-id time tracking and per-stage latency statistics (count, min, max,
// sum of squares) with a read command for one stage.
//
//  channel  dir  handshake          contents
//  s_*      in   s_tvalid/s_tready  tuser: command; tdata: id, stage, time
//  m_*      out  m_tvalid/m_tready  tuser: no_start; tdata: delta and stats
//
// A record that updates a stage goes through ST_LOOK, ST_MUL0, ST_MUL1,
// ST_FOLD and ST_DONE; a read, a start point or a flagged point goes from
// ST_LOOK to ST_DONE. The two-step 64-bit square and the read-modify-write
// of the stage table make the longer path. After reset a pass over all
// ID_ENTRIES ids clears the start flags; s_tready stays low during it.
// A held output result blocks the next item's completion, not its transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module stage_latency_statistics_core #(
	parameter int unsigned ID_ENTRIES    = 1024,
	parameter int unsigned STAGE_ENTRIES = 256
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// trace_id, stage, timestamp, zero pad
	input  wire logic [stl_pkg::S_DATA_W-1:0] s_tdata,
	// command
	input  wire logic                          s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// delta, sample_count, min_delta, max_delta, sum_squares
	output logic [stl_pkg::M_DATA_W-1:0]      m_tdata,
	// no_start
	output logic                               m_tuser
);

	localparam int unsigned IDX_W  = $clog2(ID_ENTRIES);
	localparam int unsigned SIDX_W = (STAGE_ENTRIES > 1) ? $clog2(STAGE_ENTRIES) : 1;
	localparam int unsigned TW     = stl_pkg::TIME_W;
	localparam int unsigned HW     = TW / 2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_MUL0,
		ST_MUL1,
		ST_FOLD,
		ST_DONE
	} state_t;

	state_t                       state_q;
	logic [IDX_W-1:0]             clr_q;

	logic                         cmd_q;
	logic [stl_pkg::ID_W-1:0]     id_q;
	logic [stl_pkg::STAGE_W-1:0]  stage_q;
	logic [TW-1:0]                time_q;

	logic [TW-1:0]                delta_q;
	logic                         flag_q;
	stl_pkg::stat_t               stat_q;
	stl_pkg::stat_t               res_stat_q;
	logic [TW-1:0]                p0_q;
	logic [HW-1:0]                p1_q;
	logic [TW-1:0]                acc_q;

	logic                         m_valid_q;
	logic [TW-1:0]                out_delta_q;
	logic                         out_flag_q;
	stl_pkg::stat_t               out_stat_q;

	logic                         accept;
	logic [stl_pkg::ID_W-1:0]     in_id;
	logic [stl_pkg::STAGE_W-1:0]  in_stage;
	logic                         id_ok;
	logic                         stage_ok;
	logic                         seen;
	logic [TW-1:0]                delta_now;

	stl_pkg::id_entry_t           id_rd;
	stl_pkg::id_entry_t           id_wr;
	logic                         id_we;
	logic [IDX_W-1:0]             id_waddr;
	stl_pkg::stat_t               st_rd;
	stl_pkg::stat_t               st_wr;
	logic                         st_we;
	logic                         out_room;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_id    = s_tdata[9:0];
	assign in_stage = s_tdata[17:10];

	assign id_ok     = 32'(id_q) < 32'(ID_ENTRIES);
	assign stage_ok  = 32'(stage_q) < 32'(STAGE_ENTRIES);
	assign seen      = id_rd.seen && id_ok;
	assign delta_now = time_q - id_rd.last;
	assign out_room  = !m_valid_q || m_tready;

	// id table write: clearing pass, or start / timed point
	always_comb begin
		id_we    = 1'b0;
		id_waddr = IDX_W'(id_q);
		id_wr    = '{seen: 1'b1, last: time_q};
		if (state_q == ST_CLEAR) begin
			id_we    = 1'b1;
			id_waddr = clr_q;
			id_wr    = '{seen: 1'b0, last: '0};
		end else if (state_q == ST_LOOK) begin
			id_we = (cmd_q == stl_pkg::CMD_RECORD) && id_ok &&
				((stage_q == '0) || seen);
		end
	end

	// folded statistics
	always_comb begin
		st_wr       = stat_q;
		st_wr.count = (stat_q.count == stl_pkg::COUNT_MAX) ? stat_q.count
			: stat_q.count + 1'b1;
		if (delta_q < stat_q.min) begin
			st_wr.min = delta_q;
		end
		if (delta_q > stat_q.max) begin
			st_wr.max = delta_q;
		end
		st_wr.sumsq = acc_q + {p1_q[HW-2:0], {(HW+1){1'b0}}};
		st_we       = (state_q == ST_FOLD);
	end

	stl_id_mem #(
		.ID_ENTRIES(ID_ENTRIES),
		.IDX_W     (IDX_W)
	) u_id_mem (
		.clk    (clk),
		.rd_en  (accept),
		.rd_addr(IDX_W'(in_id)),
		.rd_data(id_rd),
		.wr_en  (id_we),
		.wr_addr(id_waddr),
		.wr_data(id_wr)
	);

	stl_stage_mem #(
		.STAGE_ENTRIES(STAGE_ENTRIES),
		.SIDX_W       (SIDX_W)
	) u_stage_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(SIDX_W'(in_stage)),
		.rd_stat(st_rd),
		.wr_en  (st_we),
		.wr_addr(SIDX_W'(stage_q)),
		.wr_stat(st_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_room) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(ID_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if ((cmd_q == stl_pkg::CMD_RECORD) && id_ok && (stage_q != '0) &&
						seen && stage_ok) begin
						state_q <= ST_MUL0;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_FOLD;
				ST_FOLD: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_room) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= s_tuser;
			id_q    <= in_id;
			stage_q <= in_stage;
			time_q  <= s_tdata[81:18];
		end
		if (state_q == ST_LOOK) begin
			stat_q <= st_rd;
			if (cmd_q == stl_pkg::CMD_READ) begin
				delta_q    <= '0;
				flag_q     <= 1'b0;
				res_stat_q <= stage_ok ? st_rd : stl_pkg::STAT_EMPTY;
			end else begin
				delta_q    <= ((stage_q != '0) && seen) ? delta_now : '0;
				flag_q     <= !id_ok || ((stage_q != '0) && !seen);
				res_stat_q <= stl_pkg::STAT_ZERO;
			end
		end
		// square modulo 2^64 from two 32x32 partial products
		if (state_q == ST_MUL0) begin
			p0_q <= delta_q[HW-1:0] * delta_q[HW-1:0];
		end
		if (state_q == ST_MUL1) begin
			p1_q  <= HW'(delta_q[TW-1:HW] * delta_q[HW-1:0]);
			acc_q <= stat_q.sumsq + p0_q;
		end
		if ((state_q == ST_DONE) && out_room) begin
			out_delta_q <= delta_q;
			out_flag_q  <= flag_q;
			out_stat_q  <= res_stat_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = out_flag_q;
	assign m_tdata  = {out_stat_q.sumsq, out_stat_q.max, out_stat_q.min,
		out_stat_q.count, out_delta_q};

endmodule

`default_nettype wire
